[design/rcfd_pkg.sv]
// Shared types, constants and helpers for the remote-control frame decoder.
`default_nettype none
package rcfd_pkg;

  localparam int unsigned CH_W  = 11;
  localparam int unsigned AX_W  = 16;
  localparam int unsigned DB_W  = 10;
  localparam int unsigned CNT_W = 8;
  localparam int unsigned SW_W  = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CH_W-1:0]  CENTER       = 11'd1024;
  localparam logic [SW_W-1:0]  SW_RESET     = 4'hB;
  localparam logic [CNT_W-1:0] CNT_MAX      = 8'hFF;
  localparam logic [7:0]       PRESS_CODE   = 8'd1;

  localparam logic [DB_W-1:0]       DEADBAND_RST     = 10'd10;
  localparam logic [CFG_DATA_W-1:0] JUMP_LIMIT_RST   = 16'd150;
  localparam logic [CNT_W-1:0]      STUCK_LIMIT_RST  = 8'd50;
  localparam logic [CNT_W-1:0]      PRESS_FRAMES_RST = 8'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADBAND     = 2'd0,
    CFG_JUMP_LIMIT   = 2'd1,
    CFG_STUCK_LIMIT  = 2'd2,
    CFG_PRESS_FRAMES = 2'd3
  } cfg_idx_t;

  // Unpacked frame, channels already snapped
  typedef struct packed {
    logic            accepted;
    logic [CH_W-1:0] ch0;
    logic [CH_W-1:0] ch1;
    logic [CH_W-1:0] ch2;
    logic [CH_W-1:0] ch3;
    logic [SW_W-1:0] switches;
    logic [AX_W-1:0] mouse_x;
    logic [AX_W-1:0] mouse_y;
    logic [AX_W-1:0] mouse_z;
    logic [7:0]      press_byte;
    logic            right;
    logic [AX_W-1:0] keys;
  } rcfd_frame_t;

  // Held values shown on the result channel
  typedef struct packed {
    logic [CH_W-1:0] ch0;
    logic [CH_W-1:0] ch1;
    logic [CH_W-1:0] ch2;
    logic [CH_W-1:0] ch3;
    logic [SW_W-1:0] switches;
    logic [AX_W-1:0] mouse_x;
    logic [AX_W-1:0] mouse_y;
    logic [AX_W-1:0] mouse_z;
    logic            left;
    logic            right;
    logic [AX_W-1:0] keys;
  } rcfd_held_t;

  function automatic logic [CH_W-1:0] snap(input logic [CH_W-1:0] ch,
                                           input logic [DB_W-1:0] db);
    logic [CH_W-1:0] span;
    span = ch[CH_W-1] ? (ch - CENTER) : (CENTER - ch);
    return (span > {1'b0, db}) ? ch : CENTER;
  endfunction

endpackage
`default_nettype wire

[design/rcfd_unpack.sv]
// Frame field extraction, button-byte check and stick deadband.
`default_nettype none
module rcfd_unpack
  import rcfd_pkg::*;
(
  input  wire logic [63:0]     frame_lo,
  input  wire logic [63:0]     frame_hi,
  input  wire logic [DB_W-1:0] deadband,
  output rcfd_frame_t          frame
);

  logic [7:0] b [16];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i]     = frame_lo[8*i +: 8];
      b[i + 8] = frame_hi[8*i +: 8];
    end
  end

  always_comb begin
    frame.accepted   = (b[12][7:1] == 7'd0) && (b[13][7:1] == 7'd0);
    frame.ch0        = snap({b[1][2:0], b[0]}, deadband);
    frame.ch1        = snap({b[2][5:0], b[1][7:3]}, deadband);
    frame.ch2        = snap({b[4][0], b[3], b[2][7:6]}, deadband);
    frame.ch3        = snap({b[5][3:0], b[4][7:1]}, deadband);
    frame.switches   = b[5][7:4];
    frame.mouse_x    = {b[7], b[6]};
    frame.mouse_y    = {b[9], b[8]};
    frame.mouse_z    = {b[11], b[10]};
    frame.press_byte = b[12];
    frame.right      = b[13][0];
    frame.keys       = {b[15], b[14]};
  end

endmodule
`default_nettype wire

[design/rcfd_state.sv]
// Held frame state with mouse Y glitch/stuck filter and left-press counter.
`default_nettype none
module rcfd_state
  import rcfd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire rcfd_frame_t           frame,
  input  wire logic [CFG_DATA_W-1:0] jump_limit,
  input  wire logic [CNT_W-1:0]      stuck_limit,
  input  wire logic [CNT_W-1:0]      press_frames,
  output rcfd_held_t                 held
);

  rcfd_held_t       held_r, held_nxt;
  logic [CNT_W-1:0] repeat_r, repeat_nxt;
  logic [CNT_W-1:0] press_r, press_nxt;

  logic signed [AX_W:0] diff;
  logic [AX_W:0]        adiff;
  logic [AX_W-1:0]      y_glitch;
  logic [CNT_W-1:0]     repeat_step;

  always_comb begin
    diff  = $signed({frame.mouse_y[AX_W-1], frame.mouse_y})
          - $signed({held_r.mouse_y[AX_W-1], held_r.mouse_y});
    adiff = diff[AX_W] ? (~diff + 1'b1) : diff;
    y_glitch = (adiff > {1'b0, jump_limit}) ? held_r.mouse_y : frame.mouse_y;

    repeat_step = repeat_r;
    if ((y_glitch == held_r.mouse_y) && (y_glitch != '0) && (repeat_r != CNT_MAX)) begin
      repeat_step = repeat_r + 1'b1;
    end

    held_nxt   = held_r;
    repeat_nxt = repeat_step;
    press_nxt  = press_r;

    held_nxt.ch0      = frame.ch0;
    held_nxt.ch1      = frame.ch1;
    held_nxt.ch2      = frame.ch2;
    held_nxt.ch3      = frame.ch3;
    held_nxt.switches = frame.switches;
    held_nxt.mouse_x  = frame.mouse_x;
    held_nxt.mouse_z  = frame.mouse_z;
    held_nxt.right    = frame.right;
    held_nxt.keys     = frame.keys;
    held_nxt.mouse_y  = y_glitch;

    if (repeat_step > stuck_limit) begin
      repeat_nxt       = '0;
      held_nxt.mouse_y = '0;
    end

    if (frame.press_byte == PRESS_CODE) begin
      if (press_r != CNT_MAX) begin
        press_nxt = press_r + 1'b1;
      end
    end else begin
      press_nxt = '0;
    end
    held_nxt.left = (press_nxt > press_frames);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r.ch0      <= CENTER;
      held_r.ch1      <= CENTER;
      held_r.ch2      <= CENTER;
      held_r.ch3      <= CENTER;
      held_r.switches <= SW_RESET;
      held_r.mouse_x  <= '0;
      held_r.mouse_y  <= '0;
      held_r.mouse_z  <= '0;
      held_r.left     <= 1'b0;
      held_r.right    <= 1'b0;
      held_r.keys     <= '0;
      repeat_r        <= '0;
      press_r         <= '0;
    end else if (load && frame.accepted) begin
      held_r   <= held_nxt;
      repeat_r <= repeat_nxt;
      press_r  <= press_nxt;
    end
  end

  assign held = held_r;

endmodule
`default_nettype wire

[design/rc_frame_decode_filter.sv]
// Top level: input stage, config registers, result stage of the frame decoder.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one 16-byte frame per beat as
//   in_frame_lo (bytes 0..7) and in_frame_hi (bytes 8..15).
//   Result channel (out_valid/out_ready) returns one beat per frame: the
//   accept flag and the held stick, switch, mouse, button and key values.
//   A rejected frame still yields a beat with out_frame_accepted low and
//   the previously held values.
//   Throughput: one frame per cycle with out_ready high, set by the single
//   pass from the input register through decode and filter into the
//   held-value register.
//   Stall: with out_ready low the result beat holds; an empty input register
//   still takes one more frame, then in_ready drops until the result leaves.
//   Reset (rst_n low, synchronous): both stages empty, configuration back to
//   deadband 10, jump limit 150, stuck limit 50, press frames 6; sticks at
//   1024, switches left down / right mid, all other held values zero.
//   cfg_we writes cfg_wdata into register cfg_index at once; write only
//   while no frame is in flight.
`default_nettype none
module rc_frame_decode_filter
  import rcfd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [63:0]           in_frame_lo,
  input  wire logic [63:0]           in_frame_hi,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic                  out_frame_accepted,
  output      logic [CH_W-1:0]       out_stick_ch0,
  output      logic [CH_W-1:0]       out_stick_ch1,
  output      logic [CH_W-1:0]       out_stick_ch2,
  output      logic [CH_W-1:0]       out_stick_ch3,
  output      logic [SW_W-1:0]       out_switch_bits,
  output      logic signed [AX_W-1:0] out_mouse_x,
  output      logic signed [AX_W-1:0] out_mouse_y,
  output      logic signed [AX_W-1:0] out_mouse_z,
  output      logic                  out_left_held,
  output      logic                  out_right_button,
  output      logic [AX_W-1:0]       out_key_bits
);

  logic [DB_W-1:0]       deadband_r;
  logic [CFG_DATA_W-1:0] jump_limit_r;
  logic [CNT_W-1:0]      stuck_limit_r;
  logic [CNT_W-1:0]      press_frames_r;

  logic        in_valid_r;
  logic [63:0] frame_lo_r;
  logic [63:0] frame_hi_r;
  logic        out_valid_r;
  logic        accepted_r;
  logic        advance;

  rcfd_frame_t frame;
  rcfd_held_t  held;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r     <= DEADBAND_RST;
      jump_limit_r   <= JUMP_LIMIT_RST;
      stuck_limit_r  <= STUCK_LIMIT_RST;
      press_frames_r <= PRESS_FRAMES_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEADBAND:     deadband_r     <= cfg_wdata[DB_W-1:0];
        CFG_JUMP_LIMIT:   jump_limit_r   <= cfg_wdata;
        CFG_STUCK_LIMIT:  stuck_limit_r  <= cfg_wdata[CNT_W-1:0];
        CFG_PRESS_FRAMES: press_frames_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame_lo_r <= in_frame_lo;
      frame_hi_r <= in_frame_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      accepted_r <= frame.accepted;
    end
  end

  rcfd_unpack u_unpack (
    .frame_lo (frame_lo_r),
    .frame_hi (frame_hi_r),
    .deadband (deadband_r),
    .frame    (frame)
  );

  rcfd_state u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (advance),
    .frame        (frame),
    .jump_limit   (jump_limit_r),
    .stuck_limit  (stuck_limit_r),
    .press_frames (press_frames_r),
    .held         (held)
  );

  assign out_valid          = out_valid_r;
  assign out_frame_accepted = accepted_r;
  assign out_stick_ch0      = held.ch0;
  assign out_stick_ch1      = held.ch1;
  assign out_stick_ch2      = held.ch2;
  assign out_stick_ch3      = held.ch3;
  assign out_switch_bits    = held.switches;
  assign out_mouse_x        = held.mouse_x;
  assign out_mouse_y        = held.mouse_y;
  assign out_mouse_z        = held.mouse_z;
  assign out_left_held      = held.left;
  assign out_right_button   = held.right;
  assign out_key_bits       = held.keys;

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("processed frame produced no result beat");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !frame.accepted) |=> ($stable(out_key_bits) && $stable(out_mouse_y)
                                      && !out_frame_accepted))
    else $error("rejected frame changed held state");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipe");

endmodule
`default_nettype wire

[test/tb_rc_frame_decode_filter.sv]
// Testbench for rc_frame_decode_filter: random and directed frames against a predictor.
module tb_rc_frame_decode_filter;
  timeunit 1ns;
  timeprecision 1ps;
  import rcfd_pkg::*;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } frame_t;

  typedef struct packed {
    logic       accepted;
    rcfd_held_t held;
  } rc_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = CFG_DEADBAND;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [63:0]           in_frame_lo = '0;
  logic [63:0]           in_frame_hi = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_frame_accepted;
  logic [CH_W-1:0]       out_stick_ch0, out_stick_ch1, out_stick_ch2, out_stick_ch3;
  logic [SW_W-1:0]       out_switch_bits;
  logic [AX_W-1:0]       out_mouse_x, out_mouse_y, out_mouse_z;
  logic                  out_left_held, out_right_button;
  logic [AX_W-1:0]       out_key_bits;

  rc_frame_decode_filter DUT (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_frame_lo, .in_frame_hi,
    .out_valid, .out_ready, .out_frame_accepted,
    .out_stick_ch0, .out_stick_ch1, .out_stick_ch2, .out_stick_ch3,
    .out_switch_bits, .out_mouse_x, .out_mouse_y, .out_mouse_z,
    .out_left_held, .out_right_button, .out_key_bits
  );

  initial begin
    forever #5 clk = ~clk;
  end

  frame_t     frame_q[$];
  rc_result_t result_q[$];
  int         error_count = 0;

  // predictor configuration and state
  logic [DB_W-1:0]  db_cfg;
  logic [15:0]      jump_cfg;
  logic [CNT_W-1:0] stuck_cfg;
  logic [CNT_W-1:0] press_cfg;
  rcfd_held_t       held_now;
  logic [CNT_W-1:0] rep_cnt;
  logic [CNT_W-1:0] press_cnt;

  // stimulus generator state
  logic [15:0] gen_y = '0;
  logic        gen_press = 1'b0;
  int          gen_run = 0;

  task automatic log_error(input string msg);
    error_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) log_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic logic [CH_W-1:0] snap_center(input logic [CH_W-1:0] ch);
    int offset;
    offset = int'(ch) - 1024;
    if (offset < 0) offset = -offset;
    return (offset > int'(db_cfg)) ? ch : CENTER;
  endfunction

  function automatic rc_result_t predict_frame(input logic [63:0] lo, input logic [63:0] hi);
    rc_result_t r;
    int         y, prev, adiff;
    logic [7:0] left_b, right_b;
    left_b = hi[39:32];
    right_b = hi[47:40];
    r.accepted = (left_b < 8'd2) && (right_b < 8'd2);
    if (r.accepted) begin
      held_now.ch0 = snap_center(lo[10:0]);
      held_now.ch1 = snap_center(lo[21:11]);
      held_now.ch2 = snap_center(lo[32:22]);
      held_now.ch3 = snap_center(lo[43:33]);
      held_now.switches = lo[47:44];
      held_now.mouse_x = lo[63:48];
      held_now.mouse_z = hi[31:16];
      held_now.right = right_b[0];
      held_now.keys = hi[63:48];
      y = int'($signed(hi[15:0]));
      prev = int'($signed(held_now.mouse_y));
      adiff = (y > prev) ? y - prev : prev - y;
      if (adiff > int'(jump_cfg)) y = prev;
      if (y == prev && y != 0 && rep_cnt != CNT_MAX) rep_cnt++;
      if (rep_cnt > stuck_cfg) begin
        rep_cnt = '0;
        y = 0;
      end
      held_now.mouse_y = y[15:0];
      if (left_b == PRESS_CODE) begin
        if (press_cnt != CNT_MAX) press_cnt++;
      end else begin
        press_cnt = '0;
      end
      held_now.left = press_cnt > press_cfg;
    end
    r.held = held_now;
    return r;
  endfunction

  // sender: bursts with random gaps
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin : drive_proc
    frame_t nxt;
    logic   offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) result_q.push_back(predict_frame(in_frame_lo, in_frame_hi));
      if (!in_valid || in_ready) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (frame_q.size() != 0) begin
          nxt = frame_q.pop_front();
          in_frame_lo <= nxt.lo;
          in_frame_hi <= nxt.hi;
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        in_valid <= offer;
      end
    end
  end

  // receiver: stall pattern in modes, plus long hold-offs
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   mode = 0;
  int   mode_left = 0;
  int   beats_taken = 0;

  always @(posedge clk) begin : recv_proc
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) beats_taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && beats_taken >= 100) begin
        hold_done = 1'b1;
        hold_left = 200;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 2999) == 0) begin
        hold_left = $urandom_range(50, 150);
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 150);
        end else begin
          mode_left--;
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= !out_ready;
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_proc
    rc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        log_error("result beat with nothing pending");
      end else begin
        want = result_q.pop_front();
        check_field("accepted", 16'(out_frame_accepted), 16'(want.accepted));
        check_field("stick_ch0", 16'(out_stick_ch0), 16'(want.held.ch0));
        check_field("stick_ch1", 16'(out_stick_ch1), 16'(want.held.ch1));
        check_field("stick_ch2", 16'(out_stick_ch2), 16'(want.held.ch2));
        check_field("stick_ch3", 16'(out_stick_ch3), 16'(want.held.ch3));
        check_field("switch_bits", 16'(out_switch_bits), 16'(want.held.switches));
        check_field("mouse_x", out_mouse_x, want.held.mouse_x);
        check_field("mouse_y", out_mouse_y, want.held.mouse_y);
        check_field("mouse_z", out_mouse_z, want.held.mouse_z);
        check_field("left_held", 16'(out_left_held), 16'(want.held.left));
        check_field("right_button", 16'(out_right_button), 16'(want.held.right));
        check_field("key_bits", out_key_bits, want.held.keys);
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEADBAND:    db_cfg = val[DB_W-1:0];
      CFG_JUMP_LIMIT:  jump_cfg = val;
      CFG_STUCK_LIMIT: stuck_cfg = val[CNT_W-1:0];
      default:         press_cfg = val[CNT_W-1:0];
    endcase
  endtask

  task automatic set_config(input logic [15:0] db, input logic [15:0] jump,
                            input logic [15:0] stuck, input logic [15:0] press);
    write_reg(CFG_DEADBAND, db);
    write_reg(CFG_JUMP_LIMIT, jump);
    write_reg(CFG_STUCK_LIMIT, stuck);
    write_reg(CFG_PRESS_FRAMES, press);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (frame_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic push_frame(input logic [10:0] c0, input logic [10:0] c1,
                            input logic [10:0] c2, input logic [10:0] c3,
                            input logic [3:0] sw, input logic [15:0] mx,
                            input logic [15:0] my, input logic [15:0] mz,
                            input logic [7:0] pb, input logic [7:0] rb,
                            input logic [15:0] keys);
    frame_t f;
    f.lo = {mx, sw, c3, c2, c1, c0};
    f.hi = {keys, rb, pb, mz, my};
    frame_q.push_back(f);
  endtask

  function automatic logic [10:0] pick_stick();
    int v;
    case ($urandom_range(0, 5))
      0, 1, 2: v = $urandom_range(0, 2047);
      3, 4: begin
        v = int'(db_cfg) + int'($urandom_range(0, 2)) - 1;
        v = $urandom_range(0, 1) ? 1024 + v : 1024 - v;
      end
      default: v = $urandom_range(0, 1) ? 0 : 2047;
    endcase
    if (v < 0) v = 0;
    if (v > 2047) v = 2047;
    return v[10:0];
  endfunction

  task automatic push_random_frame();
    logic [15:0] y;
    int          delta;
    logic [7:0]  pb, rb;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: y = gen_y;
      4, 5: begin
        delta = $urandom_range(0, jump_cfg + 1);
        y = $urandom_range(0, 1) ? gen_y + delta[15:0] : gen_y - delta[15:0];
      end
      6: y = '0;
      7: y = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: y = 16'($urandom());
    endcase
    gen_y = y;
    if (gen_run == 0) begin
      gen_press = !gen_press;
      gen_run = gen_press ? $urandom_range(1, press_cfg + 3) : $urandom_range(1, 4);
    end
    gen_run--;
    pb = {7'd0, gen_press};
    rb = 8'($urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0: pb = 8'($urandom_range(2, 255));
        1: rb = 8'($urandom_range(2, 255));
        default: begin
          pb = 8'($urandom());
          rb = 8'($urandom());
        end
      endcase
    end
    push_frame(pick_stick(), pick_stick(), pick_stick(), pick_stick(), 4'($urandom()),
               16'($urandom()), y, 16'($urandom()), pb, rb, 16'($urandom()));
  endtask

  // long runs of pressed frames with Y held still drive both counters to the top
  task automatic push_saturation(input int n);
    repeat (n) begin
      push_frame(pick_stick(), pick_stick(), pick_stick(), pick_stick(), 4'($urandom()),
                 16'($urandom()), 16'd77, 16'($urandom()), PRESS_CODE,
                 8'($urandom_range(0, 1)), 16'($urandom()));
    end
  endtask

  task automatic run_phase(input logic [15:0] db, input logic [15:0] jump,
                           input logic [15:0] stuck, input logic [15:0] press, input int n);
    wait_idle();
    set_config(db, jump, stuck, press);
    repeat (n) push_random_frame();
  endtask

  initial begin
    #5_000_000;
    $display("** rc_frame_decode_filter: FAILED **");
    $finish;
  end

  initial begin : stim_proc
    int random_items;
    int n;
    frame_t ones;
    db_cfg = DEADBAND_RST;
    jump_cfg = JUMP_LIMIT_RST;
    stuck_cfg = STUCK_LIMIT_RST;
    press_cfg = PRESS_FRAMES_RST;
    held_now = '{ch0: CENTER, ch1: CENTER, ch2: CENTER, ch3: CENTER, switches: SW_RESET,
                 default: '0};
    rep_cnt = '0;
    press_cnt = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames under reset configuration
    push_frame(11'd0, 11'd0, 11'd0, 11'd0, 4'h0, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 16'h0);
    ones.lo = '1;
    ones.hi = '1;
    frame_q.push_back(ones);
    push_frame(11'd2047, 11'd2047, 11'd2047, 11'd2047, 4'hF, 16'h7FFF, 16'd100, 16'h8000,
               8'd1, 8'd1, 16'hFFFF);
    push_frame(11'd1014, 11'd1034, 11'd1013, 11'd1035, 4'h5, 16'h8000, 16'd100, 16'h7FFF,
               8'd1, 8'd0, 16'hA5A5);
    push_frame(11'd1024, 11'd1024, 11'd0, 11'd2047, 4'hA, 16'h1234, 16'd0, 16'h5678,
               8'd0, 8'd2, 16'h5A5A);
    push_frame(11'd1, 11'd2, 11'd3, 11'd4, 4'h3, 16'h0001, 16'd0, 16'h0002,
               8'd2, 8'd0, 16'h0F0F);
    push_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, 4'h6, 16'h0, 16'd251, 16'h0,
               8'd0, 8'd0, 16'h0);
    push_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, 4'h6, 16'h0, 16'd250, 16'h0,
               8'd0, 8'd0, 16'h0);
    push_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, 4'h6, 16'h0, 16'h8000, 16'h0,
               8'd0, 8'd1, 16'h0);
    repeat (9) begin
      push_frame(11'd1030, 11'd1018, 11'd1035, 11'd1012, 4'h9, 16'hFFFF, 16'd250, 16'hFFFF,
                 8'd1, 8'd0, 16'hC3C3);
    end
    push_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, 4'hB, 16'h0, 16'h0, 16'h0,
               8'd0, 8'd0, 16'h0);

    random_items = 0;
    run_phase(16'd0, 16'd0, 16'd0, 16'd0, 150);
    run_phase(16'd1023, 16'd65535, 16'd254, 16'd254, 150);

    wait_idle();
    set_config(16'd5, 16'd65535, 16'd255, 16'd255);
    push_saturation(300);
    wait_idle();
    set_config(16'd5, 16'd65535, 16'd254, 16'd254);
    push_saturation(300);
    random_items = 900;

    while (random_items < 1400) begin
      n = $urandom_range(100, 250);
      run_phase(16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, 30)),
                16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 300)),
                16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 15)),
                16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 10)),
                n);
      random_items += n;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("** rc_frame_decode_filter: PASSED **");
    end else begin
      $display("** rc_frame_decode_filter: FAILED **");
    end
    $finish;
  end

endmodule
